@@ hw/rtl/dtqa_pkg.sv @@
// ----------------------------------------------------------------------------
// Dual temperature qualifier package
// Field widths, sentinel sample codes, register indexes, status codes and the
// structs that pass between the core and its channel filters.
// ----------------------------------------------------------------------------
package dtqa_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned AVG_W      = 8;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 2;
  localparam int unsigned FLIMIT_W   = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned DEPTH_DEF  = 5;

  // Disconnected sensor (-127.0 C) and power-on value (85.0 C), raw units.
  localparam logic signed [SAMPLE_W-1:0] RAW_DISCONNECT = -12'sd2032;
  localparam logic signed [SAMPLE_W-1:0] RAW_POWER_ON   = 12'sd1360;

  localparam logic signed [SAMPLE_W-1:0] LOW_LIMIT_RST   = -12'sd160;
  localparam logic [FLIMIT_W-1:0]        FAULT_LIMIT_RST = 4'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_LIMIT = 2'd1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SOFT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_HARD = 2'd2;

  typedef struct packed {
    logic                       start;
    logic signed [SAMPLE_W-1:0] sample;
  } chan_ctl_t;

  typedef struct packed {
    logic                    busy;
    logic signed [AVG_W-1:0] held;
  } chan_sts_t;

  function automatic logic sample_ok(input logic signed [SAMPLE_W-1:0] s,
                                     input logic signed [SAMPLE_W-1:0] lim);
    return (s != RAW_DISCONNECT) && (s != RAW_POWER_ON) && (s >= lim);
  endfunction

endpackage

@@ hw/rtl/dtqa_if.sv @@
// ----------------------------------------------------------------------------
// Dual temperature qualifier channel interfaces
// Valid/ready channels for measurement rounds, results and register writes.
// ----------------------------------------------------------------------------
interface dtqa_in_if;
  logic                                      valid;
  logic                                      ready;
  logic [dtqa_pkg::COUNT_W-1:0]              sensor_count;
  logic signed [dtqa_pkg::SAMPLE_W-1:0]      sample_a;
  logic signed [dtqa_pkg::SAMPLE_W-1:0]      sample_b;

  modport source(output valid, sensor_count, sample_a, sample_b, input ready);
  modport sink(input valid, sensor_count, sample_a, sample_b, output ready);
endinterface

interface dtqa_out_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [dtqa_pkg::AVG_W-1:0]         avg_a;
  logic signed [dtqa_pkg::AVG_W-1:0]         avg_b;
  logic [dtqa_pkg::STATUS_W-1:0]             status;

  modport source(output valid, avg_a, avg_b, status, input ready);
  modport sink(input valid, avg_a, avg_b, status, output ready);
endinterface

interface dtqa_cfg_if;
  logic                                      valid;
  logic                                      ready;
  logic [dtqa_pkg::CFG_IDX_W-1:0]            reg_idx;
  logic [dtqa_pkg::CFG_DATA_W-1:0]           wdata;

  modport source(output valid, reg_idx, wdata, input ready);
  modport sink(input valid, reg_idx, wdata, output ready);
endinterface

@@ hw/rtl/dual_temp_qualify_average_core.sv @@
// ----------------------------------------------------------------------------
// Dual temperature qualify and average core
// Qualifies one measurement round from two sensors, filters each channel with
// a moving average and reports the fault status of the round.
// ----------------------------------------------------------------------------
//   channel   direction  beat carries
//   in_bus    sink       sensor_count, sample_a, sample_b
//   out_bus   source     avg_a, avg_b, status
//   cfg_bus   sink       reg_idx, wdata (0 low_limit, 1 fault_limit)
//
// A round with a valid sample passes through the filters' update, load, divide
// and finish states before the result beat; the bit-serial divider produces
// one quotient bit per cycle. A round with no valid sample starts no filter.
// One round is in work at a time; the next is taken while the previous result
// waits in the output register, which holds it until the result beat is taken.
// Reset is synchronous and active low; ring contents are not cleared.
// ----------------------------------------------------------------------------
module dual_temp_qualify_average_core #(
  parameter int unsigned DEPTH = dtqa_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dtqa_in_if.sink     in_bus,
  dtqa_out_if.source  out_bus,
  dtqa_cfg_if.sink    cfg_bus
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WORK = 1'b1;

  logic                                        state_r, state_nxt;
  logic signed [dtqa_pkg::SAMPLE_W-1:0]        low_limit_r;
  logic [dtqa_pkg::FLIMIT_W-1:0]               fault_limit_r;
  logic [dtqa_pkg::FLIMIT_W-1:0]               fail_run_r, fail_run_nxt;
  logic [dtqa_pkg::STATUS_W-1:0]               st_pend_r, st_pend_nxt;
  logic                                        out_valid_r, out_valid_nxt;
  logic signed [dtqa_pkg::AVG_W-1:0]           avg_a_r;
  logic signed [dtqa_pkg::AVG_W-1:0]           avg_b_r;
  logic [dtqa_pkg::STATUS_W-1:0]               status_r;

  logic                                        in_fire;
  logic                                        cfg_fire;
  logic                                        valid_a;
  logic                                        valid_b;
  logic [dtqa_pkg::FLIMIT_W-1:0]               fail_inc;
  logic                                        work_done;
  logic                                        out_load;
  dtqa_pkg::chan_ctl_t                         ctl_a, ctl_b;
  dtqa_pkg::chan_sts_t                         sts_a, sts_b;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign cfg_fire = cfg_bus.valid && cfg_bus.ready;

  assign in_bus.ready  = (state_r == S_IDLE);
  assign cfg_bus.ready = 1'b1;

  assign valid_a = (in_bus.sensor_count != '0) &&
                   dtqa_pkg::sample_ok(in_bus.sample_a, low_limit_r);
  assign valid_b = (in_bus.sensor_count > 2'd1) &&
                   dtqa_pkg::sample_ok(in_bus.sample_b, low_limit_r);
  assign fail_inc = fail_run_r + 4'd1;

  assign ctl_a.start  = in_fire && valid_a;
  assign ctl_a.sample = in_bus.sample_a;
  assign ctl_b.start  = in_fire && valid_b;
  assign ctl_b.sample = in_bus.sample_b;

  dtqa_chan #(.DEPTH(DEPTH)) u_chan_a (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_a),
    .sts   (sts_a)
  );

  dtqa_chan #(.DEPTH(DEPTH)) u_chan_b (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl_b),
    .sts   (sts_b)
  );

  assign work_done = (state_r == S_WORK) && !sts_a.busy && !sts_b.busy;
  assign out_load  = work_done && (!out_valid_r || out_bus.ready);

  always_comb begin
    state_nxt     = state_r;
    fail_run_nxt  = fail_run_r;
    st_pend_nxt   = st_pend_r;
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      state_nxt = S_WORK;
      // The status depends only on the round's validity and the failed-round run,
      // so it is settled at the input beat while the filters run.
      if (valid_a && valid_b) begin
        fail_run_nxt = '0;
        st_pend_nxt  = dtqa_pkg::ST_OK;
      end else if (fail_inc < fault_limit_r) begin
        fail_run_nxt = fail_inc;
        st_pend_nxt  = dtqa_pkg::ST_SOFT;
      end else begin
        fail_run_nxt = '0;
        st_pend_nxt  = dtqa_pkg::ST_HARD;
      end
    end
    if (out_load) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      fail_run_r    <= '0;
      st_pend_r     <= dtqa_pkg::ST_OK;
      out_valid_r   <= 1'b0;
      low_limit_r   <= dtqa_pkg::LOW_LIMIT_RST;
      fault_limit_r <= dtqa_pkg::FAULT_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      fail_run_r  <= fail_run_nxt;
      st_pend_r   <= st_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_fire) begin
        case (cfg_bus.reg_idx)
          dtqa_pkg::CFG_LOW_LIMIT: begin
            low_limit_r <= cfg_bus.wdata;
          end
          dtqa_pkg::CFG_FAULT_LIMIT: begin
            fault_limit_r <= cfg_bus.wdata[dtqa_pkg::FLIMIT_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      avg_a_r  <= sts_a.held;
      avg_b_r  <= sts_b.held;
      status_r <= st_pend_r;
    end
  end

  assign out_bus.valid  = out_valid_r;
  assign out_bus.avg_a  = avg_a_r;
  assign out_bus.avg_b  = avg_b_r;
  assign out_bus.status = status_r;

`ifndef SYNTHESIS
  a_idle_chans: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.ready |-> (!sts_a.busy && !sts_b.busy))
    else $error("channel filter busy while the core takes a new round");

  a_result_after_filters: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (!sts_a.busy && !sts_b.busy))
    else $error("result beat raised while a channel filter was still running");

  a_hard_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_WORK) && (st_pend_r == dtqa_pkg::ST_HARD)) |-> (fail_run_r == '0))
    else $error("failed-round run not cleared after a hard fail");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (status_r == dtqa_pkg::ST_OK || status_r == dtqa_pkg::ST_SOFT ||
                     status_r == dtqa_pkg::ST_HARD))
    else $error("result beat carries an undefined status");
`endif

endmodule

@@ hw/rtl/dtqa_chan.sv @@
// ----------------------------------------------------------------------------
// Dual temperature qualifier channel filter
// Sample ring, exact running sum and a bit-serial divider that turns the sum
// into the mean in whole degrees, truncated toward zero.
// ----------------------------------------------------------------------------
module dtqa_chan #(
  parameter int unsigned DEPTH = dtqa_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dtqa_pkg::chan_ctl_t ctl,
  output dtqa_pkg::chan_sts_t sts
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = dtqa_pkg::SAMPLE_W + CW;
  localparam int unsigned MW = SW - 5;
  localparam int unsigned BW = $clog2(MW);
  localparam int unsigned AW = dtqa_pkg::AVG_W;

  localparam logic [PW-1:0] POS_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] N_FULL   = CW'(DEPTH);
  localparam logic [BW-1:0] BIT_LAST = BW'(MW - 1);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_UPD  = 3'd1;
  localparam logic [2:0] C_LOAD = 3'd2;
  localparam logic [2:0] C_DIV  = 3'd3;
  localparam logic [2:0] C_FIN  = 3'd4;

  logic signed [dtqa_pkg::SAMPLE_W-1:0] ring_mem [DEPTH];

  logic [2:0]                            state_r, state_nxt;
  logic [PW-1:0]                         pos_r, pos_nxt;
  logic                                  full_r, full_nxt;
  logic signed [SW-1:0]                  sum_r, sum_nxt;
  logic signed [AW-1:0]                  held_r, held_nxt;
  logic [BW-1:0]                         bcnt_r, bcnt_nxt;
  logic signed [dtqa_pkg::SAMPLE_W-1:0]  samp_r;
  logic signed [dtqa_pkg::SAMPLE_W-1:0]  old_r;
  logic [MW-1:0]                         dvd_r;
  logic [CW-1:0]                         rem_r;
  logic                                  neg_r;

  logic [CW-1:0]                         n_cur;
  logic signed [dtqa_pkg::SAMPLE_W-1:0]  old_term;
  logic [SW-1:0]                         sum_abs;
  logic [CW:0]                           rem_sh;
  logic [CW:0]                           rem_sub;
  logic                                  q_bit;
  logic [AW-1:0]                         q_lo;

  assign n_cur    = full_r ? N_FULL : CW'(pos_r);
  assign old_term = full_r ? old_r : '0;
  assign sum_abs  = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);

  // One quotient bit per cycle: the dividend shifts out at the top while the
  // quotient shifts in at the bottom of the same register.
  assign rem_sh  = {rem_r, dvd_r[MW-1]};
  assign q_bit   = (rem_sh >= {1'b0, n_cur});
  assign rem_sub = q_bit ? (rem_sh - {1'b0, n_cur}) : rem_sh;
  assign q_lo    = dvd_r[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    full_nxt  = full_r;
    sum_nxt   = sum_r;
    held_nxt  = held_r;
    bcnt_nxt  = bcnt_r;
    case (state_r)
      C_IDLE: begin
        if (ctl.start) begin
          state_nxt = C_UPD;
        end
      end
      C_UPD: begin
        sum_nxt   = sum_r + SW'(samp_r) - SW'(old_term);
        pos_nxt   = (pos_r == POS_LAST) ? '0 : pos_r + PW'(1);
        full_nxt  = full_r | (pos_r == POS_LAST);
        state_nxt = C_LOAD;
      end
      C_LOAD: begin
        bcnt_nxt  = BIT_LAST;
        state_nxt = C_DIV;
      end
      C_DIV: begin
        if (bcnt_r == '0) begin
          state_nxt = C_FIN;
        end else begin
          bcnt_nxt = bcnt_r - BW'(1);
        end
      end
      C_FIN: begin
        held_nxt  = neg_r ? AW'(-q_lo) : AW'(q_lo);
        state_nxt = C_IDLE;
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      pos_r   <= '0;
      full_r  <= 1'b0;
      sum_r   <= '0;
      held_r  <= '0;
      bcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      full_r  <= full_nxt;
      sum_r   <= sum_nxt;
      held_r  <= held_nxt;
      bcnt_r  <= bcnt_nxt;
    end
  end

  // Ring storage and divider datapath.
  always_ff @(posedge clk) begin
    if (ctl.start && (state_r == C_IDLE)) begin
      samp_r <= ctl.sample;
      old_r  <= ring_mem[pos_r];
    end
    if (state_r == C_UPD) begin
      ring_mem[pos_r] <= samp_r;
    end
    if (state_r == C_LOAD) begin
      // Dropping the four fraction bits first leaves the quotient unchanged.
      dvd_r <= sum_abs[SW-2:4];
      rem_r <= '0;
      neg_r <= sum_r[SW-1];
    end else if (state_r == C_DIV) begin
      dvd_r <= {dvd_r[MW-2:0], q_bit};
      rem_r <= rem_sub[CW-1:0];
    end
  end

  assign sts.busy = (state_r != C_IDLE);
  assign sts.held = held_r;

endmodule

@@ tb/dual_temp_qualify_average_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual temperature qualify and average core testbench
// Sends measurement rounds through the input channel with random gaps and
// takes results with random stalls. Each result is checked field by field
// against a behavioural filter model held in the testbench. The run steps
// through several register settings, including the extremes, and holds the
// result channel off for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module dual_temp_qualify_average_core_tb;

  localparam int          DEPTH         = dtqa_pkg::DEPTH_DEF;
  localparam int          CYCLE_LIMIT   = 500000;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          HOLD_CYCLES   = 400;
  localparam logic [1:0]  CNT_NONE      = 2'd0;
  localparam logic [1:0]  CNT_ONE       = 2'd1;
  localparam logic [1:0]  CNT_TWO       = 2'd2;
  localparam logic [1:0]  CNT_THREE     = 2'd3;

  typedef struct {
    logic [dtqa_pkg::COUNT_W-1:0]         sensor_count;
    logic signed [dtqa_pkg::SAMPLE_W-1:0] sample_a;
    logic signed [dtqa_pkg::SAMPLE_W-1:0] sample_b;
    int unsigned                          gap;
  } round_t;

  typedef struct {
    logic signed [dtqa_pkg::AVG_W-1:0] avg_a;
    logic signed [dtqa_pkg::AVG_W-1:0] avg_b;
    logic [dtqa_pkg::STATUS_W-1:0]     status;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n;

  dtqa_in_if  in_bus ();
  dtqa_out_if out_bus ();
  dtqa_cfg_if cfg_bus ();

  dual_temp_qualify_average_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Filter model state and its copy of the registers.
  logic signed [dtqa_pkg::SAMPLE_W-1:0] flt_ring [2][DEPTH];
  int                                   flt_pos  [2];
  logic                                 flt_full [2];
  logic signed [dtqa_pkg::AVG_W-1:0]    flt_held [2];
  logic [dtqa_pkg::FLIMIT_W-1:0]        fail_streak;
  logic signed [dtqa_pkg::SAMPLE_W-1:0] lim_low;
  logic [dtqa_pkg::FLIMIT_W-1:0]        lim_fault;

  round_t      pending_rounds[$];
  reading_t    expected_readings[$];
  round_t      round_cur;
  logic        round_busy;
  logic        round_taken;
  int unsigned gap_count;
  int unsigned gap_max;
  int unsigned stall_max;
  int unsigned stall_left;
  logic        result_taken;
  logic        hold_request;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned rounds_sent;
  int unsigned results_checked;
  int unsigned settings_used;
  int unsigned status_seen [3];

  function automatic void clear_filter_model();
    for (int c = 0; c < 2; c++) begin
      for (int i = 0; i < DEPTH; i++) flt_ring[c][i] = '0;
      flt_pos[c]  = 0;
      flt_full[c] = 1'b0;
      flt_held[c] = '0;
    end
    fail_streak = '0;
    lim_low     = dtqa_pkg::LOW_LIMIT_RST;
    lim_fault   = dtqa_pkg::FAULT_LIMIT_RST;
  endfunction

  function automatic logic sample_usable(logic signed [dtqa_pkg::SAMPLE_W-1:0] s);
    return s != dtqa_pkg::RAW_DISCONNECT && s != dtqa_pkg::RAW_POWER_ON && s >= lim_low;
  endfunction

  // Store the sample and average what the ring holds so far; the sum is exact
  // and the division truncates towards zero.
  function automatic void store_and_average(int c,
                                            logic signed [dtqa_pkg::SAMPLE_W-1:0] s);
    int total;
    int n;
    flt_ring[c][flt_pos[c]] = s;
    flt_pos[c] = (flt_pos[c] == DEPTH - 1) ? 0 : flt_pos[c] + 1;
    if (flt_pos[c] == 0) flt_full[c] = 1'b1;
    n = flt_full[c] ? DEPTH : flt_pos[c];
    total = 0;
    for (int i = 0; i < n; i++) total += flt_ring[c][i];
    flt_held[c] = dtqa_pkg::AVG_W'(total / (16 * n));
  endfunction

  function automatic reading_t qualify_round(logic [dtqa_pkg::COUNT_W-1:0] cnt,
                                             logic signed [dtqa_pkg::SAMPLE_W-1:0] sa,
                                             logic signed [dtqa_pkg::SAMPLE_W-1:0] sb);
    reading_t r;
    logic     ok_a;
    logic     ok_b;
    ok_a = cnt > 0 && sample_usable(sa);
    ok_b = cnt > 1 && sample_usable(sb);
    if (ok_a) store_and_average(0, sa);
    if (ok_b) store_and_average(1, sb);
    if (ok_a && ok_b) begin
      fail_streak = '0;
      r.status    = dtqa_pkg::ST_OK;
    end else begin
      fail_streak = fail_streak + 1'b1;
      if (fail_streak < lim_fault) begin
        r.status = dtqa_pkg::ST_SOFT;
      end else begin
        r.status    = dtqa_pkg::ST_HARD;
        fail_streak = '0;
      end
    end
    r.avg_a = flt_held[0];
    r.avg_b = flt_held[1];
    return r;
  endfunction

  // Mostly plausible readings above the low limit, with the sensor codes,
  // values at and just below the limit and arbitrary bit patterns mixed in.
  function automatic logic signed [dtqa_pkg::SAMPLE_W-1:0] draw_sample();
    int pick;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 6) return dtqa_pkg::RAW_DISCONNECT;
    if (pick < 12) return dtqa_pkg::RAW_POWER_ON;
    if (pick < 16) return lim_low - dtqa_pkg::SAMPLE_W'($urandom_range(0, 1));
    if (pick < 24) return dtqa_pkg::SAMPLE_W'($urandom);
    v = int'($urandom_range(4095, int'(lim_low) + 2048)) - 2048;
    return dtqa_pkg::SAMPLE_W'(v);
  endfunction

  function automatic logic [dtqa_pkg::COUNT_W-1:0] draw_count();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return CNT_TWO;
    if (pick < 80) return CNT_THREE;
    if (pick < 90) return CNT_ONE;
    return CNT_NONE;
  endfunction

  task automatic queue_round(logic [dtqa_pkg::COUNT_W-1:0] cnt, int a, int b);
    round_t r;
    r.sensor_count = cnt;
    r.sample_a     = dtqa_pkg::SAMPLE_W'(a);
    r.sample_b     = dtqa_pkg::SAMPLE_W'(b);
    r.gap          = $urandom_range(0, gap_max);
    pending_rounds.push_back(r);
  endtask

  task automatic queue_random_rounds(int n);
    for (int i = 0; i < n; i++) queue_round(draw_count(), draw_sample(), draw_sample());
  endtask

  task automatic write_reg(logic [dtqa_pkg::CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_bus.valid   <= 1'b1;
    cfg_bus.reg_idx <= idx;
    cfg_bus.wdata   <= dtqa_pkg::CFG_DATA_W'(val);
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    if (idx == dtqa_pkg::CFG_LOW_LIMIT) lim_low = dtqa_pkg::SAMPLE_W'(val);
    else if (idx == dtqa_pkg::CFG_FAULT_LIMIT) lim_fault = dtqa_pkg::FLIMIT_W'(val);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_rounds.size() != 0 || round_busy || expected_readings.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limits(int low, int fault);
    write_reg(dtqa_pkg::CFG_LOW_LIMIT, low);
    write_reg(dtqa_pkg::CFG_FAULT_LIMIT, fault);
    settings_used++;
  endtask

  // Round driver: each beat waits out its own gap before valid is raised.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      round_busy  = 1'b0;
      round_taken = 1'b0;
      gap_count   = 0;
    end else begin
      if (round_taken) begin
        round_taken = 1'b0;
        round_busy  = 1'b0;
      end
      if (!round_busy && pending_rounds.size() != 0) begin
        if (gap_count < pending_rounds[0].gap) begin
          gap_count++;
        end else begin
          round_cur  = pending_rounds.pop_front();
          gap_count  = 0;
          round_busy = 1'b1;
          in_bus.sensor_count <= round_cur.sensor_count;
          in_bus.sample_a     <= round_cur.sample_a;
          in_bus.sample_b     <= round_cur.sample_b;
        end
      end
      in_bus.valid <= round_busy;
    end
  end

  // Long hold-off of the result channel, requested by the stimulus sequence.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      result_taken = 1'b0;
      stall_left   = $urandom_range(0, stall_max);
    end else begin
      if (result_taken) begin
        result_taken = 1'b0;
        stall_left   = $urandom_range(0, stall_max);
      end
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Monitor: checks each result beat, then predicts from each input beat.
  always @(posedge clk) begin
    reading_t want;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        result_taken = 1'b1;
        if (expected_readings.size() == 0) begin
          $error("result beat with no round awaiting it: avg_a %0d avg_b %0d status %0d",
                 out_bus.avg_a, out_bus.avg_b, out_bus.status);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          if (out_bus.avg_a !== want.avg_a) begin
            $error("avg_a: expected %0d, actual %0d", want.avg_a, out_bus.avg_a);
            mismatches++;
          end
          if (out_bus.avg_b !== want.avg_b) begin
            $error("avg_b: expected %0d, actual %0d", want.avg_b, out_bus.avg_b);
            mismatches++;
          end
          if (out_bus.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_bus.status);
            mismatches++;
          end
          if (want.status <= dtqa_pkg::ST_HARD) status_seen[want.status]++;
          results_checked++;
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        round_taken = 1'b1;
        rounds_sent++;
        expected_readings.push_back(qualify_round(in_bus.sensor_count, in_bus.sample_a,
                                                  in_bus.sample_b));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, expected_readings.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.sensor_count  = '0;
    in_bus.sample_a      = '0;
    in_bus.sample_b      = '0;
    out_bus.ready        = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.reg_idx      = '0;
    cfg_bus.wdata        = '0;
    hold_request         = 1'b0;
    hold_left            = 0;
    round_busy           = 1'b0;
    round_taken          = 1'b0;
    result_taken         = 1'b0;
    cycle_count          = 0;
    mismatches           = 0;
    rounds_sent          = 0;
    results_checked      = 0;
    settings_used        = 1;
    status_seen          = '{0, 0, 0};
    gap_max              = 3;
    stall_max            = 3;
    clear_filter_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset limits: sensor counts, sensor codes, the low limit edge and a
    // run of empty rounds long enough to reach a hard fail.
    queue_round(CNT_NONE, 0, 0);
    queue_round(CNT_ONE, 320, -2048);
    queue_round(CNT_TWO, 2047, -160);
    queue_round(CNT_TWO, -161, dtqa_pkg::RAW_DISCONNECT);
    queue_round(CNT_TWO, dtqa_pkg::RAW_POWER_ON, 2047);
    queue_round(CNT_THREE, -160, 1359);
    queue_round(CNT_THREE, 1361, -2031);
    queue_round(CNT_TWO, dtqa_pkg::RAW_DISCONNECT, dtqa_pkg::RAW_POWER_ON);
    repeat (5) queue_round(CNT_NONE, 100, 100);
    queue_round(CNT_TWO, -1, 16);
    queue_round(CNT_TWO, 0, -16);
    queue_round(CNT_TWO, 2047, 2047);
    queue_round(CNT_TWO, -160, -160);
    queue_round(CNT_TWO, 800, -17);
    wait_idle();

    // Lowest low limit, longest fault run.
    gap_max   = 11;
    stall_max = 11;
    set_limits(-2048, 15);
    queue_round(CNT_TWO, -2048, -2047);
    queue_round(CNT_TWO, dtqa_pkg::RAW_DISCONNECT, -2048);
    queue_round(CNT_TWO, 2047, -2048);
    queue_random_rounds(200);
    wait_idle();

    // Highest low limit, every failed round a hard fail.
    set_limits(2047, 1);
    queue_round(CNT_TWO, 2047, 2047);
    queue_round(CNT_TWO, 2046, 2047);
    queue_random_rounds(100);
    wait_idle();

    // A fault limit of zero also makes every failed round a hard fail.
    gap_max   = 2;
    stall_max = 5;
    set_limits(-160, 0);
    queue_random_rounds(150);
    wait_idle();

    // Back-to-back rounds while the result channel is held off, so the core
    // fills up and stops taking input beats.
    gap_max   = 0;
    stall_max = 0;
    set_limits(int'($urandom_range(0, 800)) - 400, $urandom_range(1, 15));
    queue_random_rounds(300);
    repeat (20) @(posedge clk);
    hold_request = 1'b1;
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 11;
      endcase
      case ($urandom_range(0, 2))
        0: stall_max = 0;
        1: stall_max = 3;
        default: stall_max = 11;
      endcase
      if ($urandom_range(0, 3) == 0)
        set_limits(int'($urandom_range(0, 4095)) - 2048, $urandom_range(0, 15));
      else
        set_limits(int'($urandom_range(0, 1000)) - 300, $urandom_range(1, 15));
      queue_random_rounds(200);
      wait_idle();
    end

    $display("Covered %0d rounds under %0d register settings; %0d results checked",
             rounds_sent, settings_used, results_checked);
    $display("Statuses seen: %0d good, %0d soft fail, %0d hard fail; %0d mismatches",
             status_seen[0], status_seen[1], status_seen[2], mismatches);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/dtqa_pkg.sv
hw/rtl/dtqa_if.sv
hw/rtl/dtqa_chan.sv
hw/rtl/dual_temp_qualify_average_core.sv
tb/dual_temp_qualify_average_core_tb.sv
